// File: sv/median_window_of_bounds_defines.svh
// ----------------------------------------------------------------------------
// Median window of bounds: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_WINDOW_OF_BOUNDS_DEFINES_SVH
`define MEDIAN_WINDOW_OF_BOUNDS_DEFINES_SVH

// Same-cycle implication.
`define MWB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mwb_pkg.sv
// ----------------------------------------------------------------------------
// Median window of bounds: package
// Word widths, request codes and the link between neighboring cells.
// ----------------------------------------------------------------------------
package mwb_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountOW = 5;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } mwb_op_e;

  typedef logic signed [WordW-1:0] mwb_word_t;

  // Handed from a cell to its right neighbor.
  typedef struct packed {
    logic      gt;   // new bound sorts before this cell's value
    mwb_word_t val;  // this cell's stored value
  } mwb_link_t;

endpackage

// File: sv/mwb_cell.sv
// ----------------------------------------------------------------------------
// Median window of bounds: insertion cell
// Holds one sorted bound; shifts right or captures the new bound on insert.
// ----------------------------------------------------------------------------
module mwb_cell import mwb_pkg::*; (
  input  logic      clk_i,
  input  logic      ins_i,      // insert a bound this cycle
  input  mwb_word_t new_val_i,  // bound being inserted
  input  logic      occ_i,      // cell holds a bound
  input  logic      tail_i,     // first free cell
  input  mwb_link_t left_i,     // from left neighbor
  output mwb_link_t link_o,     // to right neighbor
  output mwb_word_t val_o
);

  mwb_word_t val_q;
  mwb_word_t val_d;
  logic      gt;
  logic      wr_en;

  assign gt = occ_i && (new_val_i < val_q);

  always_comb begin
    // take the left value when the bound lands further left, else the bound
    if (left_i.gt) begin
      val_d = left_i.val;
    end else begin
      val_d = new_val_i;
    end
  end

  assign wr_en = ins_i && (left_i.gt || gt || tail_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_q <= val_d;
    end
  end

  assign link_o.gt  = gt;
  assign link_o.val = val_q;
  assign val_o      = val_q;

endmodule

// File: sv/median_window_of_bounds.sv
// ----------------------------------------------------------------------------
// Median window of bounds
// Sorted store of signed bounds kept by a row of insertion cells; a query
// returns the lower and upper median bounds or the default position.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o    | op_i, bound_value_i
//  out     | output    | out_valid_o / out_stall_i  | window_low_o, window_high_o,
//          |           |                            | stored_count_o, overflow_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (default position)
//
//  Cycles: one input word per cycle unless stalled. An add compares the bound
//  against every cell in parallel and places it in the same edge, or drops it
//  when full; a query reads the median cells through a one-hot select and
//  registers the result word, visible on the next cycle.
//  Reset: count, overflow flag, default position and output valid clear; the
//  cell values are left as they are and only occupied cells are ever read.
//  Stalls: input stall rises while a result word is held and the output is
//  stalled; otherwise a new word is taken as the held one leaves.
// ----------------------------------------------------------------------------
`include "median_window_of_bounds_defines.svh"

module median_window_of_bounds import mwb_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic signed [WordW-1:0]    bound_value_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [WordW-1:0]    window_low_o,
  output logic signed [WordW-1:0]    window_high_o,
  output logic        [CountOW-1:0]  stored_count_o,
  output logic                       overflow_o,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic signed [WordW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  mwb_word_t       dflt_q;

  logic            out_valid_q, out_valid_d;
  mwb_word_t       win_lo_q, win_lo_d;
  mwb_word_t       win_hi_q, win_hi_d;
  logic [CountOW-1:0] cnt_o_q, cnt_o_d;
  logic            ovf_o_q, ovf_o_d;

  logic            in_acc;
  logic            is_add;
  logic            is_query;
  logic            full;
  logic            ins;

  // Hold the input while a result word sits stalled at the output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_add     = in_acc && (mwb_op_e'(op_i) == OP_ADD);
  assign is_query   = in_acc && (mwb_op_e'(op_i) == OP_QUERY);
  assign full       = (32'(count_q) == 32'(CAPACITY));
  assign ins        = is_add && !full;

  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Cell row: cell 0 sits at the low end of the sorted order
  // --------------------------------------------------------------------------
  mwb_link_t links [CAPACITY+1];
  mwb_word_t cell_val [CAPACITY];

  assign links[0].gt  = 1'b0;
  assign links[0].val = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mwb_cell u_cell (
      .clk_i     (clk_i),
      .ins_i     (ins),
      .new_val_i (bound_value_i),
      .occ_i     (CntW'(i) < count_q),
      .tail_i    (CntW'(i) == count_q),
      .left_i    (links[i]),
      .link_o    (links[i+1]),
      .val_o     (cell_val[i])
    );
  end

  // --------------------------------------------------------------------------
  // Median select: lower end at (count-1)/2, upper end one further when even
  // --------------------------------------------------------------------------
  logic            empty;
  logic [CntW-1:0] center;
  logic [CntW-1:0] hi_idx;
  mwb_word_t       lo_or;
  mwb_word_t       hi_or;

  assign empty  = (count_q == '0);
  assign center = (count_q - CntW'(1)) >> 1;
  assign hi_idx = center + CntW'(!count_q[0]);

  always_comb begin
    lo_or = '0;
    hi_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (center == CntW'(i)) begin
        lo_or = lo_or | cell_val[i];
      end
      if (hi_idx == CntW'(i)) begin
        hi_or = hi_or | cell_val[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ins) begin
      count_d = count_q + CntW'(1);
    end
    if (is_add && full) begin
      // drop the bound, remember it
      ovf_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    win_lo_d    = win_lo_q;
    win_hi_d    = win_hi_q;
    cnt_o_d     = cnt_o_q;
    ovf_o_d     = ovf_o_q;
    if (is_query) begin
      out_valid_d = 1'b1;
      win_lo_d    = empty ? dflt_q : lo_or;
      win_hi_d    = empty ? dflt_q : hi_or;
      cnt_o_d     = CountOW'(32'(count_q));
      ovf_o_d     = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      dflt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dflt_q <= cfg_data_i;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    win_lo_q <= win_lo_d;
    win_hi_q <= win_hi_d;
    cnt_o_q  <= cnt_o_d;
    ovf_o_q  <= ovf_o_d;
  end

  assign out_valid_o    = out_valid_q;
  assign window_low_o   = win_lo_q;
  assign window_high_o  = win_hi_q;
  assign stored_count_o = cnt_o_q;
  assign overflow_o     = ovf_o_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MWB_ASSERT_IMPL(a_count_in_range, 1'b1, 32'(count_q) <= 32'(CAPACITY), "count above capacity")
  `MWB_ASSERT_NEXT(a_full_sets_ovf, is_add && full, ovf_q, "dropped bound did not set overflow")
  `MWB_ASSERT_NEXT(a_add_grows, ins, count_q == $past(count_q) + CntW'(1), "add did not grow count")
  `MWB_ASSERT_NEXT(a_odd_window, is_query && count_q[0], win_lo_q == win_hi_q, "odd count, ends differ")
  `MWB_ASSERT_NEXT(a_query_shows, is_query, out_valid_q, "query gave no result word")

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Median window of bounds: testbench top
// Drives add and query words with bursty timing against a random output
// stall pattern, predicts each median window from a shadow sorted store, and
// compares every result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import mwb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned MAX_CYCLES = 400_000;

  // Receiver stall behavior; the mode changes after a random hold.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // One expected result word.
  typedef struct packed {
    mwb_word_t          low;
    mwb_word_t          high;
    logic [CountOW-1:0] count;
    logic               ovf;
  } window_t;

  localparam mwb_word_t WORD_MIN = mwb_word_t'(32'h8000_0000);
  localparam mwb_word_t WORD_MAX = mwb_word_t'(32'h7FFF_FFFF);

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall_o;
  logic               in_op         = OP_ADD;
  mwb_word_t          in_bound      = '0;
  logic               out_valid_o;
  logic               out_stall     = 1'b0;
  mwb_word_t          window_low_o;
  mwb_word_t          window_high_o;
  logic [CountOW-1:0] stored_count_o;
  logic               overflow_o;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready_o;
  mwb_word_t          cfg_data      = '0;

  // Shadow copy of the block's state, advanced only on accepted words.
  mwb_word_t   shadow_bounds [CAPACITY];
  int unsigned shadow_count   = 0;
  logic        shadow_dropped = 1'b0;
  mwb_word_t   shadow_default = '0;

  window_t     pending_windows[$];

  int unsigned cycle_cnt  = 0;
  int unsigned n_words    = 0;
  int unsigned n_queries  = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  median_window_of_bounds #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (in_op),
    .bound_value_i (in_bound),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .window_low_o  (window_low_o),
    .window_high_o (window_high_o),
    .stored_count_o(stored_count_o),
    .overflow_o    (overflow_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow store
  // --------------------------------------------------------------------------

  // Insert a bound in ascending order; equal bounds go after stored ones.
  // Drop it and raise the sticky flag when the store is full.
  function automatic void place_bound(mwb_word_t v);
    int unsigned pos;
    if (shadow_count >= CAPACITY) begin
      shadow_dropped = 1'b1;
      return;
    end
    pos = shadow_count;
    while (pos > 0 && v < shadow_bounds[pos-1]) begin
      shadow_bounds[pos] = shadow_bounds[pos-1];
      pos--;
    end
    shadow_bounds[pos] = v;
    shadow_count++;
  endfunction

  // Lower and upper middle bounds, or the default position on an empty store.
  function automatic window_t median_window();
    window_t     w;
    int unsigned center;
    if (shadow_count == 0) begin
      w.low  = shadow_default;
      w.high = shadow_default;
    end else begin
      center = (shadow_count - 1) / 2;
      w.low  = shadow_bounds[center];
      if (shadow_count % 2 == 0 && center + 1 < CAPACITY) begin
        w.high = shadow_bounds[center + 1];
      end else begin
        w.high = w.low;
      end
    end
    w.count = CountOW'(shadow_count);
    w.ovf   = shadow_dropped;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and checker: all handshakes sampled on the rising edge, so every
  // value read here is the one that stood before the edge.
  // --------------------------------------------------------------------------

  task automatic check_field(string what, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    window_t exp_w;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        shadow_default = cfg_data;
      end
      // Compare the result word against the oldest pending window.
      if (out_valid_o && !out_stall) begin
        if (pending_windows.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual low %0d high %0d",
                   $time, window_low_o, window_high_o);
          n_errors++;
        end else begin
          exp_w = pending_windows.pop_front();
          check_field("window_low",   exp_w.low,   window_low_o);
          check_field("window_high",  exp_w.high,  window_high_o);
          check_field("stored_count", exp_w.count, stored_count_o);
          check_field("overflow",     exp_w.ovf,   overflow_o);
          n_checked++;
        end
      end
      // Advance the shadow store on each accepted input word.
      if (in_valid && !in_stall_o) begin
        n_words++;
        if (in_op == OP_ADD) begin
          place_bound(in_bound);
        end else begin
          n_queries++;
          pending_windows = {pending_windows, median_window()};
        end
      end
    end
  end

  // Receiver stall pattern: pick a mode, hold it for a while, then switch.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left[3:0] < 4'd9);
    endcase
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; every task is entered and left on a rising edge.
  // --------------------------------------------------------------------------

  // Present one word and hold it until it is taken; return on the accept edge.
  task automatic send_word(mwb_op_e op, mwb_word_t value);
    in_valid <= 1'b1;
    in_op    <= op;
    in_bound <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop valid, wait out every pending window, then let an add settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the default position while the block is idle.
  task automatic write_default(mwb_word_t value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Bias toward extremes and a narrow range that produces ties.
  function automatic mwb_word_t random_bound();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return mwb_word_t'(int'($urandom_range(0, 15)) - 8);
      default: return mwb_word_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty store: both ends follow the default position; bound_value on a
  // query must have no effect.
  task automatic test_empty_store();
    send_word(OP_QUERY, mwb_word_t'(32'hFFFF_FFFF));
    write_default(WORD_MAX);
    send_word(OP_QUERY, WORD_MIN);
    write_default(WORD_MIN);
    send_word(OP_QUERY, WORD_MAX);
    write_default(mwb_word_t'(-1));
    send_word(OP_QUERY, '0);
  endtask

  // Field extremes, odd and even counts, and equal bounds.
  task automatic test_extremes_and_ties();
    send_word(OP_ADD, WORD_MIN);
    send_word(OP_QUERY, WORD_MAX);
    send_word(OP_ADD, WORD_MAX);
    send_word(OP_QUERY, WORD_MIN);
    send_word(OP_ADD, '0);
    send_word(OP_ADD, '0);
    send_word(OP_QUERY, '0);
    send_word(OP_ADD, mwb_word_t'(-1));
    send_word(OP_QUERY, mwb_word_t'(-1));
    send_word(OP_ADD, mwb_word_t'(1));
    send_word(OP_QUERY, mwb_word_t'(1));
  endtask

  // Bursts of random adds and queries with random gaps between bursts.
  task automatic test_random_mix(int unsigned n_items, int unsigned add_pct);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 99) < add_pct) begin
          send_word(OP_ADD, random_bound());
        end else begin
          send_word(OP_QUERY, mwb_word_t'($urandom));
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end
  endtask

  // Full store: further adds drop, the flag sticks across queries.
  task automatic test_store_full();
    int unsigned missing;
    wait_idle();
    missing = CAPACITY - shadow_count;
    repeat (missing) send_word(OP_ADD, random_bound());
    send_word(OP_QUERY, '0);
    send_word(OP_ADD, WORD_MAX);
    send_word(OP_ADD, WORD_MIN);
    send_word(OP_QUERY, WORD_MAX);
    send_word(OP_QUERY, WORD_MIN);
  endtask

  initial begin
    // Hold reset, then release on an edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_extremes_and_ties();
    test_random_mix(400, 40);
    write_default(WORD_MAX);
    test_random_mix(400, 50);
    write_default(WORD_MIN);
    test_random_mix(400, 30);
    write_default(mwb_word_t'($urandom));
    test_random_mix(400, 60);
    write_default('0);
    test_store_full();

    // Drain the last results and let the block settle.
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d input words, %0d of them queries, over empty, partial and",
             n_words, n_queries);
    $display("full stores with several default positions; %0d result words compared.",
             n_checked);
    if (n_errors == 0 && pending_windows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
